>>> rtl/core/stgg_pkg.sv
// Package for the stepper tone gate generator.
// Holds the command codes, register indexes and the payload and configuration types.
// No dependencies.
`default_nettype none

package stgg_pkg;

    // Command codes of the input transaction; the fourth code changes nothing.
    typedef enum logic [1:0] {
        CMD_TICK     = 2'd0,
        CMD_NOTE_ON  = 2'd1,
        CMD_NOTE_OFF = 2'd2
    } t_command;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY_MS         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_MS       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REVERSE_COUNT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_ENABLE      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DIRECTION_ENABLE = 3'd4;

    // Reset value of the reverse count register.
    localparam logic [15:0] REVERSE_COUNT_RESET = 16'd80;

    // Configuration as seen by the tone engine.
    typedef struct packed {
        logic [15:0] decay_ms;
        logic [15:0] release_ms;
        logic [15:0] reverse_count;
        logic        step_enable;
        logic        direction_enable;
    } t_cfg;

    // One command item.
    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] now_us;
        logic [31:0] now_ms;
        logic [31:0] period_us;
    } t_cmd;

    // One result item.
    typedef struct packed {
        logic step_level;
        logic direction_level;
        logic sounding;
        logic release_pending;
    } t_res;

endpackage

`default_nettype wire

>>> rtl/core/stgg_cmd_if.sv
// Command channel interface of the stepper tone gate generator.
// Carries valid, ready and the command payload; no dependencies.
`default_nettype none

interface stgg_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [31:0] now_us;
    logic [31:0] now_ms;
    logic [31:0] period_us;

    modport source (output valid, command, now_us, now_ms, period_us, input ready);
    modport sink (input valid, command, now_us, now_ms, period_us, output ready);
endinterface

`default_nettype wire

>>> rtl/core/stgg_res_if.sv
// Result channel interface of the stepper tone gate generator.
// Carries valid, ready and the line levels; no dependencies.
`default_nettype none

interface stgg_res_if;
    logic valid;
    logic ready;
    logic step_level;
    logic direction_level;
    logic sounding;
    logic release_pending;

    modport source (output valid, step_level, direction_level, sounding, release_pending,
                    input ready);
    modport sink (input valid, step_level, direction_level, sounding, release_pending,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/core/stgg_cfg_if.sv
// Configuration write channel interface of the stepper tone gate generator.
// Carries valid, ready, a register index and write data; no dependencies.
`default_nettype none

interface stgg_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> rtl/core/stgg_cfg_regs.sv
// Configuration register file of the stepper tone gate generator.
// Depends on stgg_pkg for the register indexes and the t_cfg type.
`default_nettype none

module stgg_cfg_regs (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_wr_en,
    input  wire logic [stgg_pkg::CFG_IDX_W-1:0]  i_wr_index,
    input  wire logic [stgg_pkg::CFG_DATA_W-1:0] i_wr_data,
    output stgg_pkg::t_cfg                      o_cfg
);

    stgg_pkg::t_cfg r_cfg;

    // Register writes; an index beyond the list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.decay_ms         <= '0;
            r_cfg.release_ms       <= '0;
            r_cfg.reverse_count    <= stgg_pkg::REVERSE_COUNT_RESET;
            r_cfg.step_enable      <= 1'b0;
            r_cfg.direction_enable <= 1'b0;
        end else if (i_wr_en) begin
            case (i_wr_index)
                stgg_pkg::REG_DECAY_MS:         r_cfg.decay_ms <= i_wr_data;
                stgg_pkg::REG_RELEASE_MS:       r_cfg.release_ms <= i_wr_data;
                stgg_pkg::REG_REVERSE_COUNT:    r_cfg.reverse_count <= i_wr_data;
                stgg_pkg::REG_STEP_ENABLE:      r_cfg.step_enable <= i_wr_data[0];
                stgg_pkg::REG_DIRECTION_ENABLE: r_cfg.direction_enable <= i_wr_data[0];
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

>>> rtl/core/stgg_engine.sv
// Tone engine of the stepper tone gate generator: note state and its update per command.
// Depends on stgg_pkg for the command codes and the payload types.
`default_nettype none

module stgg_engine (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_fire,
    input  wire stgg_pkg::t_cmd i_cmd,
    input  wire stgg_pkg::t_cfg i_cfg,
    output stgg_pkg::t_res      o_res
);

    logic        r_step_line, n_step_line;
    logic        r_direction_line, n_direction_line;
    logic [15:0] r_step_tally, n_step_tally;
    logic        r_active, n_active;
    logic        r_release_wait, n_release_wait;
    logic [31:0] r_note_start_ms, n_note_start_ms;
    logic [31:0] r_last_toggle_us, n_last_toggle_us;
    logic [31:0] r_toggle_period_us, n_toggle_period_us;

    logic [31:0] note_age_ms;
    logic [31:0] since_toggle_us;
    logic        release_done;
    logic        decayed;

    // Wrapping ages and the release and decay tests.
    assign note_age_ms     = i_cmd.now_ms - r_note_start_ms;
    assign since_toggle_us = i_cmd.now_us - r_last_toggle_us;
    assign release_done    = (i_cfg.release_ms == 16'd0) ||
                             (note_age_ms > {16'd0, i_cfg.release_ms});
    assign decayed         = (i_cfg.decay_ms != 16'd0) &&
                             (note_age_ms > {16'd0, i_cfg.decay_ms});

    // Next state for the command in hand.
    always_comb begin
        n_step_line        = r_step_line;
        n_direction_line   = r_direction_line;
        n_step_tally       = r_step_tally;
        n_active           = r_active;
        n_release_wait     = r_release_wait;
        n_note_start_ms    = r_note_start_ms;
        n_last_toggle_us   = r_last_toggle_us;
        n_toggle_period_us = r_toggle_period_us;
        case (i_cmd.command)
            stgg_pkg::CMD_NOTE_ON: begin
                n_note_start_ms    = i_cmd.now_ms;
                n_toggle_period_us = i_cmd.period_us;
                n_active           = 1'b1;
                n_last_toggle_us   = i_cmd.now_us;
            end
            stgg_pkg::CMD_NOTE_OFF: begin
                if (release_done) begin
                    n_active       = 1'b0;
                    n_release_wait = 1'b0;
                end else begin
                    n_release_wait = 1'b1;
                end
            end
            stgg_pkg::CMD_TICK: begin
                if (r_active && i_cfg.step_enable) begin
                    // Toggle once the half period has passed, counting towards a reversal.
                    if (since_toggle_us > r_toggle_period_us) begin
                        n_step_line      = ~r_step_line;
                        n_last_toggle_us = i_cmd.now_us;
                        if (i_cfg.direction_enable) begin
                            if (r_step_tally >= i_cfg.reverse_count) begin
                                n_direction_line = ~r_direction_line;
                                n_step_tally     = 16'd0;
                            end else begin
                                n_step_tally = r_step_tally + 16'd1;
                            end
                        end
                    end
                    // Decay or pending release: end if release is done, else set pending.
                    if ((r_release_wait && release_done) || decayed) begin
                        if (release_done) begin
                            n_active       = 1'b0;
                            n_release_wait = 1'b0;
                        end else begin
                            n_release_wait = 1'b1;
                        end
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // State registers; every field is cleared or loaded with its default at reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_line        <= 1'b0;
            r_direction_line   <= 1'b0;
            r_step_tally       <= '0;
            r_active           <= 1'b0;
            r_release_wait     <= 1'b0;
            r_note_start_ms    <= '0;
            r_last_toggle_us   <= '0;
            r_toggle_period_us <= '0;
        end else if (i_fire) begin
            r_step_line        <= n_step_line;
            r_direction_line   <= n_direction_line;
            r_step_tally       <= n_step_tally;
            r_active           <= n_active;
            r_release_wait     <= n_release_wait;
            r_note_start_ms    <= n_note_start_ms;
            r_last_toggle_us   <= n_last_toggle_us;
            r_toggle_period_us <= n_toggle_period_us;
        end
    end

    // Result reflects the state after the command.
    assign o_res.step_level      = n_step_line;
    assign o_res.direction_level = n_direction_line;
    assign o_res.sounding        = n_active & i_cfg.step_enable;
    assign o_res.release_pending = n_release_wait;

    // The step line moves only when a command is processed.
    a_step_only_on_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_fire |=> $stable(r_step_line))
        else $error("step line changed without a command");

    // The direction line flips only together with a step toggle.
    a_dir_with_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_direction_line != $past(r_direction_line)) |-> (r_step_line != $past(r_step_line)))
        else $error("direction flipped without a step toggle");

    // A note_on always leaves a note active.
    a_note_on_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_cmd.command == stgg_pkg::CMD_NOTE_ON) |=> r_active)
        else $error("note_on did not start a note");

endmodule

`default_nettype wire

>>> rtl/core/stepper_tone_gate_generator.sv
// Top level of the stepper tone gate generator: input register, tone engine, result register.
// Depends on stgg_pkg, the three channel interfaces, stgg_cfg_regs and stgg_engine.
//
// Usage: each command transaction on i_cmd (tick, note_on or note_off, with the current
// microsecond and millisecond timestamps and, for note_on, the half period) produces
// exactly one result transaction on o_res with the step and direction line levels,
// whether the note is sounding and whether a release is pending.
// Configuration is written on i_cfg, one register per transaction, and is always ready;
// write it only while no command is in flight.
// A command waits in the input register until the engine fires; the engine then updates
// the note state and loads the result register, which holds the result on o_res until
// it is taken.
// Throughput: one command per cycle while o_res takes the results.
// When o_res stalls, the result register holds and the input register absorbs one more
// command before i_cmd.ready drops; no transaction is lost or repeated.
// Reset (i_rst_n low, synchronous) clears the note state and line levels, empties both
// pipeline registers, and loads the register defaults (reverse count 80, rest zero).
`default_nettype none

module stepper_tone_gate_generator (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    stgg_cmd_if.sink     i_cmd,
    stgg_res_if.source   o_res,
    stgg_cfg_if.sink     i_cfg
);

    logic           r_in_valid;
    stgg_pkg::t_cmd r_in_cmd;
    logic           r_out_valid;
    stgg_pkg::t_res r_out_res;

    logic           fire;
    logic           in_ready;
    stgg_pkg::t_cfg cfg;
    stgg_pkg::t_res eng_res;

    // Handshakes: the engine runs when the input register is full and the result slot frees.
    assign fire     = r_in_valid && (!r_out_valid || o_res.ready);
    assign in_ready = !r_in_valid || fire;
    assign i_cmd.ready = in_ready;
    assign i_cfg.ready = 1'b1;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_cmd.valid;
        end
        if (in_ready && i_cmd.valid) begin
            r_in_cmd.command   <= i_cmd.command;
            r_in_cmd.now_us    <= i_cmd.now_us;
            r_in_cmd.now_ms    <= i_cmd.now_ms;
            r_in_cmd.period_us <= i_cmd.period_us;
        end
    end

    stgg_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg.valid),
        .i_wr_index (i_cfg.index),
        .i_wr_data  (i_cfg.data),
        .o_cfg      (cfg)
    );

    stgg_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_cmd   (r_in_cmd),
        .i_cfg   (cfg),
        .o_res   (eng_res)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
        if (fire) begin
            r_out_res <= eng_res;
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.step_level      = r_out_res.step_level;
    assign o_res.direction_level = r_out_res.direction_level;
    assign o_res.sounding        = r_out_res.sounding;
    assign o_res.release_pending = r_out_res.release_pending;

endmodule

`default_nettype wire
